### rtl/mvsm_pkg.sv
`default_nettype none

package mvsm_pkg;

	typedef enum logic [1:0] {
		OP_TICK  = 2'd0,
		OP_START = 2'd1,
		OP_WRITE = 2'd2
	} op_t;

	typedef enum logic [1:0] {
		ST_FRAME   = 2'd0,
		ST_STARTED = 2'd1,
		ST_REJECT  = 2'd2,
		ST_WRITTEN = 2'd3
	} status_t;

	localparam logic LOOP_ENABLE = 1'b1;

	localparam logic [15:0] MASTER_RESET = 16'd16384;

	localparam int SAMPLE_W  = 16;
	localparam int GAIN_W    = 16;
	localparam int MIX_SHIFT = 28;

	typedef logic signed [SAMPLE_W-1:0] sample_t;

	typedef struct packed {
		logic clear;
		logic add;
	} mix_ctrl_t;

endpackage

`default_nettype wire

### rtl/mvsm_ifs.sv
`default_nettype none

interface mvsm_cmd_if;
	logic        valid;
	logic        ready;
	logic [1:0]  op;
	logic [15:0] sample_address;
	logic [16:0] sample_length;
	logic signed [15:0] left_in;
	logic signed [15:0] right_in;
	logic [15:0] voice_volume;
	logic        loop_flag;

	modport source (
		output valid, op, sample_address, sample_length, left_in, right_in,
		       voice_volume, loop_flag,
		input  ready
	);

	modport sink (
		input  valid, op, sample_address, sample_length, left_in, right_in,
		       voice_volume, loop_flag,
		output ready
	);
endinterface

interface mvsm_rsp_if;
	logic        valid;
	logic        ready;
	logic [1:0]  status;
	logic signed [15:0] left_out;
	logic signed [15:0] right_out;
	logic [2:0]  voice_slot;

	modport source (
		output valid, status, left_out, right_out, voice_slot,
		input  ready
	);

	modport sink (
		input  valid, status, left_out, right_out, voice_slot,
		output ready
	);
endinterface

`default_nettype wire

### rtl/multi_voice_sample_mixer.sv
// Stereo sample-playback mixer. Items arrive on cmd and each gives exactly one
// item on rsp. A write item stores one stereo frame in the sample memory, a
// start item claims the lowest free voice, and a tick item mixes every active
// voice into one saturated left and right frame and then advances the voices.
// The master gain is written through cfg_we and cfg_data; the user must write
// it only while the block idles, as the block itself does not enforce this.
//
// One item is in work at a time. A tick visits one voice record per cycle in
// the voice memory, then reads the sample memory and multiplies in a short
// pipeline. Start and write items pass through a two-stage address reduction;
// rejected starts and unknown operations skip it. The next item is taken in
// the same cycle as a result is raised.
//
// A finished item waits in the output register; the next item is taken while
// it waits, and only a further result stalls until the receiver takes it.
// Reset frees every voice and sets the master gain to unity. The sample memory
// is not cleared: its contents are undefined until written.
`default_nettype none

module multi_voice_sample_mixer #(
	parameter int NUM_VOICES   = 8,
	parameter int SAMPLE_DEPTH = 65536
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [15:0]       cfg_data,
	mvsm_cmd_if.sink          cmd,
	mvsm_rsp_if.source        rsp
);

	localparam int VW = (NUM_VOICES > 1) ? $clog2(NUM_VOICES) : 1;
	localparam int AW = $clog2(SAMPLE_DEPTH);
	localparam int CW = $clog2(NUM_VOICES + 3);
	localparam logic [CW-1:0] TICK_READS = CW'(NUM_VOICES);
	localparam logic [CW-1:0] TICK_LAST  = CW'(NUM_VOICES + 2);

	typedef struct packed {
		logic                        looping;
		logic [AW-1:0]               base;
		logic [16:0]                 frames;
		logic [15:0]                 cursor;
		logic [mvsm_pkg::GAIN_W-1:0] gain;
		logic [AW-1:0]               addr;
	} voice_rec_t;

	localparam int VREC_W = $bits(voice_rec_t);

	typedef enum logic [4:0] {
		S_IDLE   = 5'b00001,
		S_REDUCE = 5'b00010,
		S_TICK   = 5'b00100,
		S_FIN    = 5'b01000,
		S_DONE   = 5'b10000
	} state_t;

	state_t                state_q;
	logic [15:0]           master_q;
	logic [NUM_VOICES-1:0] busy_q;
	logic [CW-1:0]         cnt_q;

	logic                  accept;
	logic                  start_ok;
	logic                  any_free;
	logic [VW-1:0]         free_idx;

	logic [16:0]           cmd_len_q;
	logic [15:0]           cmd_gain_q;
	logic                  cmd_loop_q;
	logic [15:0]           cmd_left_q;
	logic [15:0]           cmd_right_q;
	logic                  is_start_q;
	logic [VW-1:0]         slot_q;

	mvsm_pkg::status_t     res_status_q;
	mvsm_pkg::sample_t     res_left_q;
	mvsm_pkg::sample_t     res_right_q;
	logic [2:0]            res_slot_q;

	logic                  rsp_valid_q;
	mvsm_pkg::status_t     rsp_status_q;
	mvsm_pkg::sample_t     rsp_left_q;
	mvsm_pkg::sample_t     rsp_right_q;
	logic [2:0]            rsp_slot_q;
	logic                  rsp_load;

	logic                  rd_vld_s1;
	logic                  rd_busy_s1;
	logic [VW-1:0]         rd_idx_s1;
	logic                  en_s2;
	logic [31:0]           gain_s2;

	voice_rec_t            rec;
	voice_rec_t            upd;
	voice_rec_t            new_rec;
	logic                  p1_act;
	logic [16:0]           cur_p1;
	logic                  ended;
	logic [15:0]           next_cur;
	logic [AW:0]           addr_p1;
	logic [AW-1:0]         next_addr;

	logic                  vram_we;
	logic [VW-1:0]         vram_waddr;
	logic [VREC_W-1:0]     vram_wdata;
	logic [VW-1:0]         vram_raddr;
	logic [VREC_W-1:0]     vram_rdata;

	logic                  sram_we;
	logic [31:0]           sram_rdata;

	logic                  red_start;
	logic                  red_valid;
	logic [AW-1:0]         red_addr;
	logic                  commit;

	mvsm_pkg::mix_ctrl_t   mix_ctrl;
	mvsm_pkg::sample_t     left_mix;
	mvsm_pkg::sample_t     right_mix;

	assign cmd.ready = (state_q == S_IDLE);
	assign accept    = cmd.valid && cmd.ready;

	always_comb begin
		free_idx = '0;
		for (int i = NUM_VOICES - 1; i >= 0; i--) begin
			if (!busy_q[i]) begin
				free_idx = VW'(i);
			end
		end
	end

	assign any_free  = ~&busy_q;
	assign start_ok  = (cmd.sample_length != 17'd0) && any_free;
	assign red_start = accept && ((cmd.op == mvsm_pkg::OP_START && start_ok) ||
	                              cmd.op == mvsm_pkg::OP_WRITE);
	assign commit    = (state_q == S_REDUCE) && red_valid;
	assign rsp_load  = (state_q == S_DONE) && (!rsp_valid_q || rsp.ready);

	// Record update for the voice whose entry has just been read.
	assign rec      = voice_rec_t'(vram_rdata);
	assign p1_act   = rd_vld_s1 && rd_busy_s1;
	assign cur_p1   = {1'b0, rec.cursor} + 17'd1;
	assign ended    = cur_p1 >= rec.frames;
	assign next_cur = (ended && rec.looping) ? 16'd0 : cur_p1[15:0];
	assign addr_p1  = {1'b0, rec.addr} + (AW + 1)'(1);

	always_comb begin
		if (next_cur == 16'd0) begin
			next_addr = rec.base;
		end else if (addr_p1 == (AW + 1)'(SAMPLE_DEPTH)) begin
			next_addr = '0;
		end else begin
			next_addr = addr_p1[AW-1:0];
		end
	end

	always_comb begin
		upd        = rec;
		upd.cursor = next_cur;
		upd.addr   = next_addr;
	end

	always_comb begin
		new_rec.looping = (cmd_loop_q == mvsm_pkg::LOOP_ENABLE);
		new_rec.base    = red_addr;
		new_rec.frames  = cmd_len_q;
		new_rec.cursor  = 16'd0;
		new_rec.gain    = cmd_gain_q;
		new_rec.addr    = red_addr;
	end

	always_comb begin
		vram_we    = 1'b0;
		vram_waddr = rd_idx_s1;
		vram_wdata = upd;
		if (p1_act) begin
			vram_we = 1'b1;
		end else if (commit && is_start_q) begin
			vram_we    = 1'b1;
			vram_waddr = slot_q;
			vram_wdata = new_rec;
		end
	end

	assign vram_raddr = cnt_q[VW-1:0];
	assign sram_we    = commit && !is_start_q;

	assign mix_ctrl.clear = accept && (cmd.op == mvsm_pkg::OP_TICK);
	assign mix_ctrl.add   = en_s2;

	mvsm_ram #(
		.WIDTH (VREC_W),
		.DEPTH (NUM_VOICES)
	) u_voice_ram (
		.clk   (clk),
		.we    (vram_we),
		.waddr (vram_waddr),
		.wdata (vram_wdata),
		.raddr (vram_raddr),
		.rdata (vram_rdata)
	);

	mvsm_ram #(
		.WIDTH (32),
		.DEPTH (SAMPLE_DEPTH)
	) u_sample_ram (
		.clk   (clk),
		.we    (sram_we),
		.waddr (red_addr),
		.wdata ({cmd_right_q, cmd_left_q}),
		.raddr (rec.addr),
		.rdata (sram_rdata)
	);

	mvsm_addr_reduce #(
		.SAMPLE_DEPTH (SAMPLE_DEPTH)
	) u_addr_reduce (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (red_start),
		.x      (cmd.sample_address),
		.valid  (red_valid),
		.r      (red_addr)
	);

	mvsm_mix_acc #(
		.NUM_VOICES (NUM_VOICES)
	) u_mix_acc (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctrl      (mix_ctrl),
		.frame     (sram_rdata),
		.gain      (gain_s2),
		.left_sat  (left_mix),
		.right_sat (right_mix)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			master_q <= mvsm_pkg::MASTER_RESET;
		end else if (cfg_we) begin
			master_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= '0;
		end else begin
			if (p1_act && ended && !rec.looping) begin
				busy_q[rd_idx_s1] <= 1'b0;
			end
			if (commit && is_start_q) begin
				busy_q[slot_q] <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			rsp_valid_q <= 1'b0;
			rd_vld_s1   <= 1'b0;
			en_s2       <= 1'b0;
		end else begin
			rd_vld_s1 <= (state_q == S_TICK) && (cnt_q < TICK_READS);
			en_s2     <= p1_act;
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						cnt_q <= '0;
						case (cmd.op)
							mvsm_pkg::OP_TICK:  state_q <= S_TICK;
							mvsm_pkg::OP_START: state_q <= start_ok ? S_REDUCE : S_DONE;
							mvsm_pkg::OP_WRITE: state_q <= S_REDUCE;
							default:            state_q <= S_DONE;
						endcase
					end
				end
				S_REDUCE: begin
					if (red_valid) begin
						state_q <= S_DONE;
					end
				end
				S_TICK: begin
					cnt_q <= cnt_q + CW'(1);
					if (cnt_q == TICK_LAST) begin
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (rsp_load) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		rd_busy_s1 <= (cnt_q < TICK_READS) && busy_q[cnt_q[VW-1:0]];
		rd_idx_s1  <= cnt_q[VW-1:0];
		gain_s2    <= master_q * rec.gain;

		if (accept) begin
			cmd_len_q   <= cmd.sample_length;
			cmd_gain_q  <= cmd.voice_volume;
			cmd_loop_q  <= cmd.loop_flag;
			cmd_left_q  <= cmd.left_in;
			cmd_right_q <= cmd.right_in;
			is_start_q  <= (cmd.op == mvsm_pkg::OP_START);
			slot_q      <= free_idx;
			res_left_q  <= '0;
			res_right_q <= '0;
			case (cmd.op)
				mvsm_pkg::OP_START: begin
					if (start_ok) begin
						res_status_q <= mvsm_pkg::ST_STARTED;
						res_slot_q   <= 3'(free_idx);
					end else begin
						res_status_q <= mvsm_pkg::ST_REJECT;
						res_slot_q   <= '0;
					end
				end
				mvsm_pkg::OP_WRITE: begin
					res_status_q <= mvsm_pkg::ST_WRITTEN;
					res_slot_q   <= '0;
				end
				default: begin
					res_status_q <= mvsm_pkg::ST_REJECT;
					res_slot_q   <= '0;
				end
			endcase
		end

		if (state_q == S_FIN) begin
			res_status_q <= mvsm_pkg::ST_FRAME;
			res_left_q   <= left_mix;
			res_right_q  <= right_mix;
		end

		if (rsp_load) begin
			rsp_status_q <= res_status_q;
			rsp_left_q   <= res_left_q;
			rsp_right_q  <= res_right_q;
			rsp_slot_q   <= res_slot_q;
		end
	end

	assign rsp.valid      = rsp_valid_q;
	assign rsp.status     = rsp_status_q;
	assign rsp.left_out   = rsp_left_q;
	assign rsp.right_out  = rsp_right_q;
	assign rsp.voice_slot = rsp_slot_q;

	a_rsp_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid_q) |-> $past(state_q == S_DONE))
		else $error("response raised outside the completion state");

	a_tick_only_frees: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_TICK) |=> ($countones(busy_q) <= $countones($past(busy_q))))
		else $error("a voice was claimed during a tick");

	a_start_claims: assert property (@(posedge clk) disable iff (!arst_n)
		(commit && is_start_q) |=> busy_q[slot_q])
		else $error("started voice not marked busy");

endmodule

`default_nettype wire

### rtl/mvsm_ram.sv
`default_nettype none

module mvsm_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

### rtl/mvsm_addr_reduce.sv
`default_nettype none

module mvsm_addr_reduce #(
	parameter int SAMPLE_DEPTH = 65536,
	localparam int AW = $clog2(SAMPLE_DEPTH)
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [15:0]   x,
	output logic          valid,
	output logic [AW-1:0] r
);

	logic vld_s1;
	logic vld_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			vld_s1 <= start;
			vld_s2 <= vld_s1;
		end
	end

	assign valid = vld_s2;

	generate
		if (SAMPLE_DEPTH >= 65536) begin : g_wide
			logic [15:0] x_s1;
			logic [15:0] x_s2;

			always_ff @(posedge clk) begin
				x_s1 <= x;
				x_s2 <= x_s1;
			end

			assign r = AW'(x_s2);
		end else begin : g_narrow
			// Quotient by a rounded-up reciprocal; exact for a 16-bit dividend
			// because the depth stays below 2^16 on this branch.
			localparam longint unsigned RECIP =
				((64'd1 << 32) + 64'(SAMPLE_DEPTH) - 64'd1) / 64'(SAMPLE_DEPTH);
			localparam int RW = $clog2(RECIP + 64'd1);
			localparam int QW = RW - 16;
			localparam logic [RW-1:0] RECIP_C = RW'(RECIP);
			localparam logic [15:0] DEPTH_C = 16'(SAMPLE_DEPTH);

			logic [RW+15:0] prod_s1;
			logic [15:0]    x_s1;
			logic [QW-1:0]  quot;
			logic [QW+15:0] qd;
			logic [AW-1:0]  r_s2;

			assign quot = prod_s1[RW+15:32];
			assign qd   = quot * DEPTH_C;

			always_ff @(posedge clk) begin
				prod_s1 <= x * RECIP_C;
				x_s1    <= x;
				r_s2    <= AW'(x_s1 - qd[15:0]);
			end

			assign r = r_s2;
		end
	endgenerate

endmodule

`default_nettype wire

### rtl/mvsm_mix_acc.sv
`default_nettype none

module mvsm_mix_acc #(
	parameter int NUM_VOICES = 8
) (
	input  logic                clk,
	input  logic                arst_n,
	input  mvsm_pkg::mix_ctrl_t ctrl,
	input  logic [31:0]         frame,
	input  logic [31:0]         gain,
	output mvsm_pkg::sample_t   left_sat,
	output mvsm_pkg::sample_t   right_sat
);

	localparam int PROD_W = mvsm_pkg::SAMPLE_W + 2 * mvsm_pkg::GAIN_W + 1;
	localparam int ACC_W  = PROD_W + ((NUM_VOICES > 1) ? $clog2(NUM_VOICES) : 0);
	localparam int QW     = ACC_W - mvsm_pkg::MIX_SHIFT;
	localparam logic signed [ACC_W-1:0] BIAS =
		ACC_W'((64'd1 << mvsm_pkg::MIX_SHIFT) - 64'd1);
	localparam logic signed [QW-1:0] SAT_HI = QW'(32767);
	localparam logic signed [QW-1:0] SAT_LO = QW'(-32768);

	logic signed [PROD_W-1:0] prod_l_s1;
	logic signed [PROD_W-1:0] prod_r_s1;
	logic                     add_s1;
	logic signed [ACC_W-1:0]  acc_l_q;
	logic signed [ACC_W-1:0]  acc_r_q;

	// Truncation toward zero by the Q28 shift, then clipping to 16 bits.
	function automatic mvsm_pkg::sample_t sat_mix(input logic signed [ACC_W-1:0] acc);
		logic signed [ACC_W-1:0] biased;
		logic signed [QW-1:0]    quo;
		biased = acc[ACC_W-1] ? acc + BIAS : acc;
		quo    = biased[ACC_W-1:mvsm_pkg::MIX_SHIFT];
		if (quo > SAT_HI) begin
			return 16'h7fff;
		end else if (quo < SAT_LO) begin
			return 16'h8000;
		end else begin
			return quo[15:0];
		end
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			add_s1 <= 1'b0;
		end else begin
			add_s1 <= ctrl.add;
		end
	end

	always_ff @(posedge clk) begin
		prod_l_s1 <= $signed(frame[15:0]) * $signed({1'b0, gain});
		prod_r_s1 <= $signed(frame[31:16]) * $signed({1'b0, gain});
		if (ctrl.clear) begin
			acc_l_q <= '0;
			acc_r_q <= '0;
		end else if (add_s1) begin
			acc_l_q <= acc_l_q + ACC_W'(prod_l_s1);
			acc_r_q <= acc_r_q + ACC_W'(prod_r_s1);
		end
	end

	assign left_sat  = sat_mix(acc_l_q);
	assign right_sat = sat_mix(acc_r_q);

endmodule

`default_nettype wire
